[hw/rtl/srtr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Scanline triangle rasterizer package
// Shared constants, types and helpers for the rasterizer and its divider.
// ============================================================================
package srtr_pkg;

    localparam int SCREEN_WIDTH  = 512;
    localparam int SCREEN_HEIGHT = 512;
    localparam int FRAC_BITS     = 4;

    localparam int NPIX   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(NPIX);
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROWI_W = $clog2(SCREEN_HEIGHT);

    // Shift from 12.4 vertex fixed point to 34.16.
    localparam int SH = 16 - FRAC_BITS;
    // Signed 34.16 positions and slopes, and the divider operand widths.
    localparam int PW    = 50;
    localparam int NUM_W = PW;
    localparam int DEN_W = 32;
    // Signed row counter and the width used for row compares.
    localparam int IW = 18;
    localparam int CW = IW + 8;

    localparam logic [31:0] DRAW_COLOR_RESET  = 32'hFFFF_FFFF;
    localparam logic [31:0] CLEAR_COLOR_RESET = 32'hFF00_0000;

    localparam logic CFG_DRAW_COLOR  = 1'b0;
    localparam logic CFG_CLEAR_COLOR = 1'b1;

    typedef enum logic [1:0] {
        FUNC_CLEAR    = 2'd0,
        FUNC_DRAW     = 2'd1,
        FUNC_READ     = 2'd2,
        FUNC_RESERVED = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_SORT,
        ST_CLASSIFY,
        ST_MUL,
        ST_DIVM_GO,
        ST_DIVM_WAIT,
        ST_SETUP,
        ST_DIVL_GO,
        ST_DIVL_WAIT,
        ST_DIVR_GO,
        ST_DIVR_WAIT,
        ST_ROW,
        ST_PIX
    } t_state;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_vtx;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic [DEN_W-1:0]        den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [NUM_W-1:0] quo;
    } t_div_rsp;

    // Vertex coordinate to signed 34.16.
    function automatic logic signed [PW-1:0] to_fx(input logic signed [15:0] v);
        logic signed [PW-1:0] w;
        w = PW'(v);
        return w <<< SH;
    endfunction

    // Pixel row of a vertex y, truncated toward zero.
    function automatic logic signed [IW-1:0] trunc_row(input logic signed [15:0] y);
        logic signed [16:0] t;
        t = $signed({y[15], y}) + (y[15] ? $signed(17'((1 << FRAC_BITS) - 1)) : 17'sd0);
        return IW'(t >>> FRAC_BITS);
    endfunction

endpackage

[hw/rtl/srtr_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// Rasterizer divider
// Restoring divider, one quotient bit per cycle, signed dividend over a
// positive divisor, quotient truncated toward zero.
// ============================================================================
module srtr_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  srtr_pkg::t_div_req  i_req,
    output srtr_pkg::t_div_rsp  o_rsp
);

    localparam int CNT_W = $clog2(srtr_pkg::NUM_W);

    logic                          r_busy;
    logic                          r_done;
    logic                          r_neg;
    logic [CNT_W-1:0]              r_cnt;
    logic [srtr_pkg::NUM_W-1:0]    r_mag;
    logic [srtr_pkg::DEN_W-1:0]    r_rem;
    logic [srtr_pkg::DEN_W-1:0]    r_den;

    logic [srtr_pkg::DEN_W:0]      trial;
    logic [srtr_pkg::DEN_W:0]      diff;
    logic                          ge;
    logic [srtr_pkg::DEN_W-1:0]    n_rem;
    logic [srtr_pkg::NUM_W-1:0]    start_mag;

    always_comb begin
        trial     = {r_rem, r_mag[srtr_pkg::NUM_W-1]};
        diff      = trial - {1'b0, r_den};
        ge        = trial >= {1'b0, r_den};
        n_rem     = ge ? diff[srtr_pkg::DEN_W-1:0] : trial[srtr_pkg::DEN_W-1:0];
        start_mag = i_req.num[srtr_pkg::NUM_W-1] ? $unsigned(-i_req.num)
                                                 : $unsigned(i_req.num);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(srtr_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag <= start_mag;
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num[srtr_pkg::NUM_W-1];
        end else if (r_busy) begin
            r_mag <= {r_mag[srtr_pkg::NUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

[hw/rtl/scanline_triangle_rasterizer_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// Scanline triangle rasterizer
// Frame store of packed ARGB pixels with clear, triangle fill and pixel read.
// ============================================================================
// Requests arrive on the slave stream: tuser carries the request kind (clear,
// draw, read), tdata the three vertices and the pixel address of a read. The
// block takes one request at a time; tready is high only while it is idle.
// A read gives one transfer on the master stream; clear and draw give none.
// The result sits in an output register, so a stalled receiver does not hold
// up the next request: only a further read waits until that register drains.
// A read goes through the registered read port and then the output register,
// and waits before it issues while an earlier result is still held there. A
// clear writes every pixel in turn, limited by the single write port of the
// frame memory. A draw first sorts and classifies the vertices, then runs its
// divisions one after another in the shared 50-step divider: a flat-edge
// triangle needs two divisions, a split triangle five. Each row walked then
// takes one row test plus one write per covered on-screen pixel, and each part
// ends with one more row test. A triangle with all three heights equal is
// dropped once it is classified. After reset the block sweeps the whole frame
// memory to the reset clear color and holds tready low until done;
// configuration writes are taken at any time.
// ============================================================================
module scanline_triangle_rasterizer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // tdata from bit 0: vert_a_x[15:0], vert_a_y[31:16], vert_b_x[47:32],
    // vert_b_y[63:48], vert_c_x[79:64], vert_c_y[95:80], read_col[104:96],
    // read_row[113:105], zero fill[119:114].
    input  logic [119:0] i_s_axis_tdata,
    // tuser: func[1:0].
    input  logic [1:0]   i_s_axis_tuser,
    // Result stream.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // tdata: pixel_word[31:0].
    output logic [31:0]  o_m_axis_tdata,
    // Configuration writes.
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int PW    = srtr_pkg::PW;
    localparam int XP_W  = PW - 16;
    localparam int IW    = srtr_pkg::IW;
    localparam int CW    = srtr_pkg::CW;
    localparam int COL_W = srtr_pkg::COL_W;
    localparam int ADDR_W = srtr_pkg::ADDR_W;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    srtr_pkg::t_state            r_state, n_state;
    logic [31:0]                 r_draw_color;
    logic [31:0]                 r_clear_color;
    logic [31:0]                 r_fill;
    logic [ADDR_W-1:0]           r_addr;
    srtr_pkg::t_vtx              r_va, r_vb, r_vc;
    srtr_pkg::t_vtx              r_v0, r_v1, r_v2;
    logic                        r_general;
    logic                        r_part;       // 0: flat-bottom part, 1: flat-top part
    logic signed [33:0]          r_prod;
    logic signed [PW-1:0]        r_m2x;
    logic signed [PW-1:0]        r_apex_x;
    logic signed [15:0]          r_fy;
    logic signed [PW-1:0]        r_lx, r_rx;
    logic [srtr_pkg::DEN_W-1:0]  r_dy;
    logic signed [IW-1:0]        r_i;
    logic signed [PW-1:0]        r_sl, r_sr;
    logic signed [PW-1:0]        r_xl, r_xr;
    logic [srtr_pkg::ROWI_W-1:0] r_prow;
    logic [COL_W-1:0]            r_col, r_col_end;
    logic [8:0]                  r_rd_col, r_rd_row;
    logic                        r_out_valid;
    logic [31:0]                 r_out_data;
    logic [31:0]                 r_rdata;

    logic [31:0]                 mem [srtr_pkg::NPIX];

    // ------------------------------------------------------------------------
    // Combinational signals
    // ------------------------------------------------------------------------
    srtr_pkg::t_func             in_func;
    srtr_pkg::t_vtx              in_va, in_vb, in_vc;
    srtr_pkg::t_vtx              p0, p1, p2, q0, q1, q2, s0, s1, s2;
    logic signed [16:0]          dy01, dy12, dy02, dx02;
    logic signed [PW-1:0]        su_ea, su_eb, su_apex_x;
    logic signed [15:0]          su_apex_y;
    logic signed [16:0]          su_dy;
    logic                        rd_in_range;
    logic                        row_cont;
    logic                        row_on;
    logic signed [XP_W-1:0]      xl_pix, xr_pix, j0;
    logic                        span_any;
    logic [COL_W-1:0]            jend;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [31:0]                 mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    srtr_pkg::t_div_req          div_req;
    srtr_pkg::t_div_rsp          div_rsp;

    assign in_func = srtr_pkg::t_func'(i_s_axis_tuser);
    assign in_va   = '{x: i_s_axis_tdata[15:0],  y: i_s_axis_tdata[31:16]};
    assign in_vb   = '{x: i_s_axis_tdata[47:32], y: i_s_axis_tdata[63:48]};
    assign in_vc   = '{x: i_s_axis_tdata[79:64], y: i_s_axis_tdata[95:80]};

    // Stable three-way sort by y; equal y keeps the order a, b, c.
    always_comb begin
        p0 = r_va;
        p1 = r_vb;
        p2 = r_vc;
        if ($signed(r_vb.y) < $signed(r_va.y)) begin
            p0 = r_vb;
            p1 = r_va;
        end
        q0 = p0;
        q1 = p1;
        q2 = p2;
        if ($signed(p2.y) < $signed(p1.y)) begin
            q1 = p2;
            q2 = p1;
        end
        s0 = q0;
        s1 = q1;
        s2 = q2;
        if ($signed(q1.y) < $signed(q0.y)) begin
            s0 = q1;
            s1 = q0;
        end
    end

    assign dy01 = $signed({r_v1.y[15], r_v1.y}) - $signed({r_v0.y[15], r_v0.y});
    assign dy12 = $signed({r_v2.y[15], r_v2.y}) - $signed({r_v1.y[15], r_v1.y});
    assign dy02 = $signed({r_v2.y[15], r_v2.y}) - $signed({r_v0.y[15], r_v0.y});
    assign dx02 = $signed({r_v2.x[15], r_v2.x}) - $signed({r_v0.x[15], r_v0.x});

    // Part setup. Both parts walk from their apex and add the slope each row,
    // so the flat-top slope is taken with the edge minus apex as dividend.
    always_comb begin
        if (!r_part) begin
            su_apex_x = srtr_pkg::to_fx(r_v0.x);
            su_apex_y = r_v0.y;
            su_ea     = r_general ? r_m2x : srtr_pkg::to_fx(r_v1.x);
            su_eb     = r_general ? srtr_pkg::to_fx(r_v1.x) : srtr_pkg::to_fx(r_v2.x);
            su_dy     = dy01;
        end else begin
            su_apex_x = srtr_pkg::to_fx(r_v2.x);
            su_apex_y = r_v2.y;
            su_ea     = r_general ? srtr_pkg::to_fx(r_v1.x) : srtr_pkg::to_fx(r_v0.x);
            su_eb     = r_general ? r_m2x : srtr_pkg::to_fx(r_v1.x);
            su_dy     = dy12;
        end
    end

    assign rd_in_range = (int'(r_rd_col) < srtr_pkg::SCREEN_WIDTH)
                      && (int'(r_rd_row) < srtr_pkg::SCREEN_HEIGHT);

    // Row test and span limits for the current row.
    always_comb begin
        if (!r_part) begin
            row_cont = (CW'(r_i) <<< srtr_pkg::FRAC_BITS) <= CW'(r_fy);
        end else begin
            row_cont = (CW'(r_i) <<< srtr_pkg::FRAC_BITS) > CW'(r_fy);
        end
        row_on   = !r_i[IW-1] && (r_i < $signed(IW'(srtr_pkg::SCREEN_HEIGHT)));
        xl_pix   = r_xl[PW-1:16];
        xr_pix   = r_xr[PW-1:16];
        j0       = r_xl[PW-1] ? '0 : xl_pix;
        span_any = row_on && !r_xr[PW-1] && (j0 <= xr_pix)
                && (j0 < $signed(XP_W'(srtr_pkg::SCREEN_WIDTH)));
        jend     = (xr_pix >= $signed(XP_W'(srtr_pkg::SCREEN_WIDTH)))
                 ? COL_W'(srtr_pkg::SCREEN_WIDTH - 1) : xr_pix[COL_W-1:0];
    end

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            srtr_pkg::ST_CLEAR: begin
                if (r_addr == ADDR_W'(srtr_pkg::NPIX - 1)) n_state = srtr_pkg::ST_IDLE;
            end
            srtr_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (in_func)
                        srtr_pkg::FUNC_CLEAR: n_state = srtr_pkg::ST_CLEAR;
                        srtr_pkg::FUNC_DRAW:  n_state = srtr_pkg::ST_SORT;
                        srtr_pkg::FUNC_READ:  n_state = srtr_pkg::ST_RD_ISSUE;
                        default:              n_state = srtr_pkg::ST_IDLE;
                    endcase
                end
            end
            srtr_pkg::ST_RD_ISSUE: begin
                if (!r_out_valid) begin
                    n_state = rd_in_range ? srtr_pkg::ST_RD_DATA : srtr_pkg::ST_IDLE;
                end
            end
            srtr_pkg::ST_RD_DATA: n_state = srtr_pkg::ST_IDLE;
            srtr_pkg::ST_SORT:    n_state = srtr_pkg::ST_CLASSIFY;
            srtr_pkg::ST_CLASSIFY: begin
                if (r_v0.y == r_v2.y) begin
                    n_state = srtr_pkg::ST_IDLE;
                end else if (r_v1.y == r_v2.y || r_v0.y == r_v1.y) begin
                    n_state = srtr_pkg::ST_SETUP;
                end else begin
                    n_state = srtr_pkg::ST_MUL;
                end
            end
            srtr_pkg::ST_MUL:     n_state = srtr_pkg::ST_DIVM_GO;
            srtr_pkg::ST_DIVM_GO: n_state = srtr_pkg::ST_DIVM_WAIT;
            srtr_pkg::ST_DIVM_WAIT: begin
                if (div_rsp.done) n_state = srtr_pkg::ST_SETUP;
            end
            srtr_pkg::ST_SETUP:   n_state = srtr_pkg::ST_DIVL_GO;
            srtr_pkg::ST_DIVL_GO: n_state = srtr_pkg::ST_DIVL_WAIT;
            srtr_pkg::ST_DIVL_WAIT: begin
                if (div_rsp.done) n_state = srtr_pkg::ST_DIVR_GO;
            end
            srtr_pkg::ST_DIVR_GO: n_state = srtr_pkg::ST_DIVR_WAIT;
            srtr_pkg::ST_DIVR_WAIT: begin
                if (div_rsp.done) n_state = srtr_pkg::ST_ROW;
            end
            srtr_pkg::ST_ROW: begin
                if (!row_cont) begin
                    n_state = (!r_part && r_general) ? srtr_pkg::ST_SETUP : srtr_pkg::ST_IDLE;
                end else if (span_any) begin
                    n_state = srtr_pkg::ST_PIX;
                end
            end
            srtr_pkg::ST_PIX: begin
                if (r_col == r_col_end) n_state = srtr_pkg::ST_ROW;
            end
            default: n_state = srtr_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs of the sequencer: memory ports, divider request, handshake
    // ------------------------------------------------------------------------
    always_comb begin
        o_s_axis_tready = (r_state == srtr_pkg::ST_IDLE);
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = r_fill;
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(r_rd_row * srtr_pkg::SCREEN_WIDTH) + ADDR_W'(r_rd_col);
        div_req     = '0;
        div_req.den = r_dy;
        case (r_state)
            srtr_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            srtr_pkg::ST_PIX: begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(r_prow * srtr_pkg::SCREEN_WIDTH) + ADDR_W'(r_col);
                mem_wdata = r_draw_color;
            end
            srtr_pkg::ST_RD_ISSUE: begin
                mem_re = !r_out_valid && rd_in_range;
            end
            srtr_pkg::ST_DIVM_GO: begin
                div_req.start = 1'b1;
                div_req.num   = srtr_pkg::NUM_W'(r_prod) <<< srtr_pkg::SH;
                div_req.den   = srtr_pkg::DEN_W'($unsigned(dy02));
            end
            srtr_pkg::ST_DIVL_GO: begin
                div_req.start = 1'b1;
                div_req.num   = (r_lx - r_apex_x) <<< 16;
            end
            srtr_pkg::ST_DIVR_GO: begin
                div_req.start = 1'b1;
                div_req.num   = (r_rx - r_apex_x) <<< 16;
            end
            default: begin
            end
        endcase
    end

    srtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Frame memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= srtr_pkg::ST_CLEAR;
            r_addr        <= '0;
            r_fill        <= srtr_pkg::CLEAR_COLOR_RESET;
            r_out_valid   <= 1'b0;
            r_draw_color  <= srtr_pkg::DRAW_COLOR_RESET;
            r_clear_color <= srtr_pkg::CLEAR_COLOR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    srtr_pkg::CFG_DRAW_COLOR:  r_draw_color  <= i_cfg_data;
                    srtr_pkg::CFG_CLEAR_COLOR: r_clear_color <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_state == srtr_pkg::ST_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end else if (r_state == srtr_pkg::ST_IDLE && i_s_axis_tvalid
                         && in_func == srtr_pkg::FUNC_CLEAR) begin
                // Each sweep latches the clear color it started with.
                r_addr <= '0;
                r_fill <= r_clear_color;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end else if (r_state == srtr_pkg::ST_RD_DATA) begin
                r_out_valid <= 1'b1;
            end else if (r_state == srtr_pkg::ST_RD_ISSUE && !r_out_valid && !rd_in_range) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            srtr_pkg::ST_IDLE: begin
                r_va     <= in_va;
                r_vb     <= in_vb;
                r_vc     <= in_vc;
                r_rd_col <= i_s_axis_tdata[104:96];
                r_rd_row <= i_s_axis_tdata[113:105];
            end
            srtr_pkg::ST_RD_ISSUE: begin
                // A result still waiting for the receiver stays untouched.
                if (!r_out_valid) r_out_data <= '0;
            end
            srtr_pkg::ST_RD_DATA: begin
                r_out_data <= r_rdata;
            end
            srtr_pkg::ST_SORT: begin
                r_v0 <= s0;
                r_v1 <= s1;
                r_v2 <= s2;
            end
            srtr_pkg::ST_CLASSIFY: begin
                r_general <= (r_v1.y != r_v2.y) && (r_v0.y != r_v1.y);
                r_part    <= (r_v1.y != r_v2.y) && (r_v0.y == r_v1.y);
            end
            srtr_pkg::ST_MUL: begin
                r_prod <= dy01 * dx02;
            end
            srtr_pkg::ST_DIVM_WAIT: begin
                if (div_rsp.done) r_m2x <= srtr_pkg::to_fx(r_v0.x) + div_rsp.quo;
            end
            srtr_pkg::ST_SETUP: begin
                r_apex_x <= su_apex_x;
                r_fy     <= r_v1.y;
                r_lx     <= (su_ea < su_eb) ? su_ea : su_eb;
                r_rx     <= (su_ea < su_eb) ? su_eb : su_ea;
                r_dy     <= srtr_pkg::DEN_W'($unsigned(su_dy)) << srtr_pkg::SH;
                r_i      <= srtr_pkg::trunc_row(su_apex_y);
            end
            srtr_pkg::ST_DIVL_WAIT: begin
                if (div_rsp.done) r_sl <= div_rsp.quo;
            end
            srtr_pkg::ST_DIVR_WAIT: begin
                if (div_rsp.done) begin
                    r_sr <= div_rsp.quo;
                    r_xl <= r_apex_x;
                    r_xr <= r_apex_x;
                end
            end
            srtr_pkg::ST_ROW: begin
                if (row_cont) begin
                    r_prow    <= r_i[srtr_pkg::ROWI_W-1:0];
                    r_col     <= j0[COL_W-1:0];
                    r_col_end <= jend;
                    r_xl      <= r_xl + r_sl;
                    r_xr      <= r_xr + r_sr;
                    r_i       <= r_part ? (r_i - 1'b1) : (r_i + 1'b1);
                end else if (!r_part) begin
                    // Switch to the flat-top part; only a split triangle goes on to draw it.
                    r_part <= 1'b1;
                end
            end
            srtr_pkg::ST_PIX: begin
                r_col <= r_col + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == srtr_pkg::ST_CLEAR || r_state == srtr_pkg::ST_PIX))
        else $error("frame memory written outside a sweep or a span");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srtr_pkg::ST_PIX) |-> (r_col <= r_col_end))
        else $error("span column ran past its end");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == srtr_pkg::ST_RD_DATA
                             || $past(r_state) == srtr_pkg::ST_RD_ISSUE))
        else $error("result produced without a read request");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == srtr_pkg::ST_DIVM_WAIT
                       || r_state == srtr_pkg::ST_DIVL_WAIT
                       || r_state == srtr_pkg::ST_DIVR_WAIT))
        else $error("divider finished while nobody waited for it");

endmodule

[tb/sv/scanline_triangle_rasterizer_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// Scanline triangle rasterizer testbench
// Drives clear, draw, read and unused requests under random stalls on both
// streams. A scoreboard keeps its own copy of the frame store and checks
// every pixel read against it.
// ============================================================================
module scanline_triangle_rasterizer_top_test;

    // Scoreboard: a shadow frame store that follows every accepted request,
    // plus the queue of pixel words that reads still owe us.
    class raster_scoreboard;
        bit [31:0] frame[srtr_pkg::NPIX];
        bit [31:0] draw_color;
        bit [31:0] clear_color;
        bit [31:0] pending_words[$];
        int        errors;
        int        n_clear, n_draw, n_read, n_other, n_checked;

        function new();
            draw_color  = srtr_pkg::DRAW_COLOR_RESET;
            clear_color = srtr_pkg::CLEAR_COLOR_RESET;
            foreach (frame[k]) frame[k] = srtr_pkg::CLEAR_COLOR_RESET;
        endfunction

        function void span(longint row, longint xl, longint xr);
            longint j;
            if (row < 0 || row >= srtr_pkg::SCREEN_HEIGHT) return;
            j = xl / 65536;
            if (j < 0) j = 0;
            for (; j < srtr_pkg::SCREEN_WIDTH && j * 65536 <= xr; j++)
                frame[row * srtr_pkg::SCREEN_WIDTH + j] = draw_color;
        endfunction

        // Apex above a horizontal edge at height fy between x values p and q.
        function void fill_down(longint tx, longint ty, longint p, longint q, longint fy);
            longint lx, rx, dy, sl, sr, xl, xr, i;
            lx = (p < q) ? p : q;
            rx = (p < q) ? q : p;
            dy = fy - ty;
            if (dy <= 0) return;
            sl = ((lx - tx) * 65536) / dy;
            sr = ((rx - tx) * 65536) / dy;
            xl = tx;
            xr = tx;
            for (i = ty / 65536; i * 65536 <= fy; i++) begin
                span(i, xl, xr);
                xl += sl;
                xr += sr;
            end
        endfunction

        // Apex below a horizontal edge; rows are walked upward.
        function void fill_up(longint bx, longint by, longint p, longint q, longint fy);
            longint lx, rx, dy, sl, sr, xl, xr, i;
            lx = (p < q) ? p : q;
            rx = (p < q) ? q : p;
            dy = by - fy;
            if (dy <= 0) return;
            sl = ((bx - lx) * 65536) / dy;
            sr = ((bx - rx) * 65536) / dy;
            xl = bx;
            xr = bx;
            for (i = by / 65536; i * 65536 > fy; i--) begin
                span(i, xl, xr);
                xl -= sl;
                xr -= sr;
            end
        endfunction

        function void draw_triangle(logic [95:0] v);
            longint vx[3], vy[3], t, num, den, mx;
            longint sc;
            sc = longint'(1) << srtr_pkg::SH;
            for (int k = 0; k < 3; k++) begin
                vx[k] = longint'($signed(v[32*k +: 16])) * sc;
                vy[k] = longint'($signed(v[32*k + 16 +: 16])) * sc;
            end
            // Stable sort by y: equal heights keep their input order.
            if (vy[1] < vy[0]) begin
                t = vx[0]; vx[0] = vx[1]; vx[1] = t; t = vy[0]; vy[0] = vy[1]; vy[1] = t;
            end
            if (vy[2] < vy[1]) begin
                t = vx[1]; vx[1] = vx[2]; vx[2] = t; t = vy[1]; vy[1] = vy[2]; vy[2] = t;
            end
            if (vy[1] < vy[0]) begin
                t = vx[0]; vx[0] = vx[1]; vx[1] = t; t = vy[0]; vy[0] = vy[1]; vy[1] = t;
            end
            if (vy[0] == vy[2]) return;
            if (vy[1] == vy[2]) begin
                fill_down(vx[0], vy[0], vx[1], vx[2], vy[1]);
                return;
            end
            if (vy[0] == vy[1]) begin
                fill_up(vx[2], vy[2], vx[0], vx[1], vy[0]);
                return;
            end
            num = ((vy[1] - vy[0]) / sc) * ((vx[2] - vx[0]) / sc) * sc;
            den = (vy[2] - vy[0]) / sc;
            mx  = vx[0] + num / den;
            fill_down(vx[0], vy[0], mx, vx[1], vy[1]);
            fill_up(vx[2], vy[2], vx[1], mx, vy[1]);
        endfunction

        function void note_request(srtr_pkg::t_func f, logic [119:0] d);
            case (f)
                srtr_pkg::FUNC_CLEAR: begin
                    foreach (frame[k]) frame[k] = clear_color;
                    n_clear++;
                end
                srtr_pkg::FUNC_DRAW: begin
                    draw_triangle(d[95:0]);
                    n_draw++;
                end
                srtr_pkg::FUNC_READ: begin
                    pending_words.push_back(frame[{d[113:105], d[104:96]}]);
                    n_read++;
                end
                default: n_other++;
            endcase
        endfunction

        function void check_pixel(logic [31:0] got);
            bit [31:0] want;
            if (pending_words.size() == 0) begin
                $error("unexpected result transfer, pixel_word actual %08h", got);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            n_checked++;
            if (got !== want) begin
                $error("pixel_word mismatch: expected %08h actual %08h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [119:0] i_s_axis_tdata = '0;
    logic [1:0]   i_s_axis_tuser = srtr_pkg::FUNC_CLEAR;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [31:0]  o_m_axis_tdata;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = srtr_pkg::CFG_DRAW_COLOR;
    logic [31:0]  i_cfg_data = '0;

    raster_scoreboard sb = new();

    // Idle percentages for the request sender and the result receiver.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Last pixel drawn near, so reads land on fresh triangles half the time.
    int hot_col = 0;
    int hot_row = 0;

    always #1 i_clk = ~i_clk;

    scanline_triangle_rasterizer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // The receiver stalls at random; its ready changes on the falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Every result transfer is checked against the oldest pending read.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_pixel(o_m_axis_tdata);
    end

    // Offers one request, with a random number of idle cycles first, and
    // holds it until the block takes the transfer.
    task automatic send_request(srtr_pkg::t_func f, logic [119:0] d);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser  = f;
        i_s_axis_tdata  = d;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_request(f, d);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Waits until every read has answered and the block is idle again, so
    // that a clear or draw still in progress has finished.
    task automatic settle();
        while (sb.pending_words.size() != 0) @(negedge i_clk);
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Register writes happen only while the block is settled.
    task automatic cfg_write(logic idx, logic [31:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == srtr_pkg::CFG_DRAW_COLOR) sb.draw_color = val;
        else sb.clear_color = val;
    endtask

    function automatic logic [119:0] tri_data(logic [15:0] ax, logic [15:0] ay,
                                              logic [15:0] bx, logic [15:0] by,
                                              logic [15:0] cx, logic [15:0] cy);
        return {6'b0, 9'($urandom), 9'($urandom), cy, cx, by, bx, ay, ax};
    endfunction

    function automatic logic [119:0] read_data(int col, int row);
        logic [119:0] d;
        d = 120'({$urandom, $urandom, $urandom, $urandom});
        d[119:114] = '0;
        d[104:96]  = 9'(col);
        d[113:105] = 9'(row);
        return d;
    endfunction

    // A coordinate within spread of a center, kept inside the 16-bit range.
    function automatic logic [15:0] near(int center, int spread);
        int v;
        v = center + $urandom_range(0, 2 * spread) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // One random request. Most draws are small triangles on screen; some
    // sit anywhere in the coordinate range, and a few are larger.
    task automatic random_request();
        int pick, sz, mx, my;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            sz = $urandom_range(0, 199);
            sz = (sz < 2) ? 4096 : (sz < 18) ? 1024 : 256;
            if ($urandom_range(0, 9) < 7) begin
                mx = $urandom_range(0, srtr_pkg::SCREEN_WIDTH * 16 - 1);
                my = $urandom_range(0, srtr_pkg::SCREEN_HEIGHT * 16 - 1);
            end else begin
                mx = $signed(16'($urandom));
                my = $signed(16'($urandom));
            end
            // Now and then force a shared height to hit the flat-edge cases.
            if ($urandom_range(0, 9) == 0)
                send_request(srtr_pkg::FUNC_DRAW,
                             tri_data(near(mx, sz), 16'(my), near(mx, sz),
                                      16'(my), near(mx, sz), near(my, sz)));
            else
                send_request(srtr_pkg::FUNC_DRAW,
                             tri_data(near(mx, sz), near(my, sz), near(mx, sz),
                                      near(my, sz), near(mx, sz), near(my, sz)));
            hot_col = mx >>> 4;
            hot_row = my >>> 4;
        end else if (pick < 97) begin
            if ($urandom_range(0, 1) == 0)
                send_request(srtr_pkg::FUNC_READ,
                             read_data(hot_col + $urandom_range(0, 8) - 4,
                                       hot_row + $urandom_range(0, 8) - 4));
            else
                send_request(srtr_pkg::FUNC_READ, read_data($urandom, $urandom));
        end else begin
            send_request(srtr_pkg::FUNC_RESERVED, {6'b0, {3{$urandom}}, 18'($urandom)});
        end
    endtask

    // Main sequence: directed corners, then three random phases with
    // different stall patterns and register settings between them.
    initial begin
        int n;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset contents and the default draw color.
        send_request(srtr_pkg::FUNC_READ, read_data(0, 0));
        send_request(srtr_pkg::FUNC_READ, read_data(511, 511));
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'd160, 16'd160, 16'd480, 16'd160, 16'd320, 16'd480));
        send_request(srtr_pkg::FUNC_READ, read_data(20, 15));
        send_request(srtr_pkg::FUNC_READ, read_data(20, 5));
        settle();
        cfg_write(srtr_pkg::CFG_DRAW_COLOR, 32'h0000_0000);
        cfg_write(srtr_pkg::CFG_CLEAR_COLOR, 32'hFFFF_FFFF);
        // Clear with the new color, then redraw in black.
        send_request(srtr_pkg::FUNC_CLEAR, '0);
        send_request(srtr_pkg::FUNC_READ, read_data(300, 200));
        // General triangle split at its middle vertex.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'd800, 16'd320, 16'd1600, 16'd960, 16'd480, 16'd1440));
        send_request(srtr_pkg::FUNC_READ, read_data(60, 60));
        // Flat top: first two vertices share y, so sorting keeps their order.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'd3200, 16'd1600, 16'd2400, 16'd1600, 16'd2800, 16'd2400));
        send_request(srtr_pkg::FUNC_READ, read_data(175, 110));
        // All heights equal: nothing drawn.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'd100, 16'd48, 16'd4000, 16'd48, 16'd2000, 16'd48));
        send_request(srtr_pkg::FUNC_READ, read_data(100, 3));
        // Horizontal extremes of x, a thin band of rows.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'h8000, 16'd32, 16'h7FFF, 16'd32, 16'd0, 16'd80));
        send_request(srtr_pkg::FUNC_READ, read_data(511, 2));
        // Vertical extremes of y, a thin sliver that walks many off-screen rows.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'd0, 16'h8000, 16'd40, 16'h7FFF, 16'd8, 16'd0));
        send_request(srtr_pkg::FUNC_READ, read_data(0, 1));
        // Crossed edges through a negative corner, and an unused request.
        send_request(srtr_pkg::FUNC_DRAW,
                     tri_data(16'hFF00, 16'hFFF0, 16'd64, 16'd200, 16'hFFE0, 16'd100));
        send_request(srtr_pkg::FUNC_RESERVED, {6'b0, {3{32'hFFFF_FFFF}}, 18'h3FFFF});
        send_request(srtr_pkg::FUNC_READ, read_data(1, 10));
        send_request(srtr_pkg::FUNC_READ, read_data(511, 0));
        settle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 85 : 0;
            recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 31 : 0;
            case (phase)
                0: begin
                    cfg_write(srtr_pkg::CFG_DRAW_COLOR, 32'hFFFF_FFFF);
                    cfg_write(srtr_pkg::CFG_CLEAR_COLOR, 32'h0000_0000);
                end
                1: begin
                    cfg_write(srtr_pkg::CFG_DRAW_COLOR, $urandom);
                    cfg_write(srtr_pkg::CFG_CLEAR_COLOR, $urandom);
                end
                default: cfg_write(srtr_pkg::CFG_DRAW_COLOR, $urandom);
            endcase
            n = 0;
            while (n < 625) begin
                // One clear in the middle run; clears are slow.
                if (phase == 1 && n == 300) send_request(srtr_pkg::FUNC_CLEAR, '0);
                random_request();
                n++;
                // Hold off the sender until everything has drained, then
                // pick a new draw color while the block is idle.
                if (n % 200 == 0) begin
                    settle();
                    cfg_write(srtr_pkg::CFG_DRAW_COLOR, $urandom);
                end
            end
            settle();
        end

        repeat (20) @(negedge i_clk);
        $display("Ran %0d draws, %0d reads, %0d clears and %0d unused requests;",
                 sb.n_draw, sb.n_read, sb.n_clear, sb.n_other);
        $display("checked %0d pixel words under three stall patterns.", sb.n_checked);
        if (sb.errors == 0 && sb.pending_words.size() == 0) begin
            $display("PASS scanline_triangle_rasterizer_top");
        end else begin
            if (sb.pending_words.size() != 0)
                $error("%0d pixel words never arrived", sb.pending_words.size());
            $display("FAIL scanline_triangle_rasterizer_top");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("FAIL scanline_triangle_rasterizer_top");
        $finish;
    end

endmodule

[scanline_triangle_rasterizer_top.f]
hw/rtl/srtr_pkg.sv
hw/rtl/srtr_div.sv
hw/rtl/scanline_triangle_rasterizer_top.sv
tb/sv/scanline_triangle_rasterizer_top_test.sv
